// ===== sv/ogi_pkg.sv =====
// Shared constants and types for the occupancy grid inflation block.
`default_nettype none

package ogi_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 15;

    localparam int GW_W   = 11;
    localparam int GH_W   = 16;
    localparam int RAD_W  = 4;
    localparam int CELL_W = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = GH_W + 1;
    localparam int LINE_LEN = 2 * MAX_RADIUS + 1;
    localparam int DIST_SAT = 2 * MAX_RADIUS + 1;
    localparam int DIST_W   = $clog2(DIST_SAT + 1);
    localparam int WIN_W    = COL_W + 2;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS      = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic             top;
        logic             emit;
        logic             last;
    } ogi_s1_t;

endpackage

`default_nettype wire

// ===== sv/ogi_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module ogi_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 5,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ogi_row_win.sv =====
// Cell shift line and clipped horizontal window OR around the center cell.
`default_nettype none

module ogi_row_win
    import ogi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             shift_en,
    input  wire logic             cell_bit,
    input  wire logic [COL_W-1:0] center_x,
    input  wire logic [GW_W-1:0]  w_eff,
    input  wire logic [RAD_W-1:0] r_eff,
    output logic                  hit
);

    logic [LINE_LEN-1:0] line_reg;
    logic [LINE_LEN-1:0] line_next;
    logic [LINE_LEN-1:0] mask;
    logic [WIN_W-1:0]    r_ext;
    logic [WIN_W-1:0]    r_twice;
    logic [WIN_W-1:0]    left_lim;
    logic [WIN_W-1:0]    right_room;

    always_comb
    begin
        line_next = line_reg;
        if (clear)
        begin
            line_next = '0;
        end
        else if (shift_en)
        begin
            line_next = {line_reg[LINE_LEN-2:0], cell_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
        end
        else
        begin
            line_reg <= line_next;
        end
    end

    // tap j holds cell center+r-j; keep taps inside the window and the row
    always_comb
    begin
        r_ext      = WIN_W'(r_eff);
        r_twice    = r_ext + r_ext;
        left_lim   = r_ext + WIN_W'(center_x);
        right_room = WIN_W'(w_eff) - WIN_W'(1) - WIN_W'(center_x);
        for (int j = 0; j < LINE_LEN; j++)
        begin
            mask[j] = (WIN_W'(j) <= r_twice) && (WIN_W'(j) <= left_lim)
                   && ((WIN_W'(j) + right_room) >= r_ext);
        end
        hit = |(line_reg & mask);
    end

endmodule

`default_nettype wire

// ===== sv/occupancy_grid_inflation.sv =====
// Top level: streaming square-kernel dilation of an occupancy grid.
//
//  channel   signals                               direction
//  input     in_valid/in_ready, cell_value, drain  in
//  output    out_valid/out_ready, occupied, last   out
//  config    cfg_we, cfg_index, cfg_data           in (write only)
//
// One item per cycle sustained while the output is not stalled; a result is registered
// after the item that completes its window (radius*width+radius items after its own cell).
// Vertical reach is a per-column distance memory, read at accept and written back
// when the working stage advances; the last write is forwarded for same-column items.
// A register write restarts the stream; no clearing pass, row zero overwrites.
// A stalled output holds the working stage and stops input acceptance.
`default_nettype none

module occupancy_grid_inflation
    import ogi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CELL_W-1:0] cell_value,
    input  wire logic              drain,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   occupied,
    output logic                   last,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [GW_W-1:0]   w_reg,   w_next;
    logic [GH_W-1:0]   h_reg,   h_next;
    logic [RAD_W-1:0]  r_reg,   r_next;
    logic [COL_W-1:0]  in_x_reg, in_x_next;
    logic [ROW_W-1:0]  in_y_reg, in_y_next;
    logic [RAD_W-1:0]  pre_reg, pre_next;
    logic [COL_W-1:0]  hx_reg,  hx_next;
    logic [ROW_W-1:0]  hy_reg,  hy_next;
    logic              done_reg, done_next;
    logic              s1_valid_reg, s1_valid_next;
    ogi_s1_t           s1_reg,  s1_next;
    logic [COL_W-1:0]  wb_addr_reg;
    logic [DIST_W-1:0] wb_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              occupied_reg, last_reg;

    logic              restart;
    logic [GW_W-1:0]   cfg_w;
    logic              in_fire;
    logic              s1_go;
    logic              s1_fire;
    logic              center_ok;
    logic              s1_load;
    logic              cell_bit;
    logic              row_end_in;
    logic              row_end_h;
    logic [ROW_W-1:0]  last_row;
    logic              hit;
    logic [DIST_W-1:0] mem_rdata;
    logic [DIST_W-1:0] d_prev;
    logic [DIST_W-1:0] d_new;
    logic [DIST_W-1:0] d_limit;

    assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH
                             || cfg_index == REG_GRID_HEIGHT
                             || cfg_index == REG_RADIUS);
    assign cfg_w   = cfg_data[GW_W-1:0];

    assign s1_go    = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_go;
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    assign center_ok  = (pre_reg == r_reg);
    assign s1_load    = in_fire && !done_reg && center_ok;
    assign cell_bit   = !drain && (in_y_reg < ROW_W'(h_reg)) && (cell_value != '0);
    assign row_end_in = (GW_W'(in_x_reg) == w_reg - GW_W'(1));
    assign row_end_h  = (GW_W'(hx_reg) == w_reg - GW_W'(1));
    assign last_row   = ROW_W'(h_reg) - ROW_W'(1) + ROW_W'(r_reg);

    always_comb
    begin
        w_next         = w_reg;
        h_next         = h_reg;
        r_next         = r_reg;
        in_x_next      = in_x_reg;
        in_y_next      = in_y_reg;
        pre_next       = pre_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        done_next      = done_reg;
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;

        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_fire && s1_reg.emit)
        begin
            out_valid_next = 1'b1;
        end

        if (restart)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:
                begin
                    if (cfg_w == '0)
                    begin
                        w_next = GW_W'(1);
                    end
                    else if (cfg_w > GW_W'(MAX_WIDTH))
                    begin
                        w_next = GW_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        w_next = cfg_w;
                    end
                end
                REG_GRID_HEIGHT:
                begin
                    h_next = (cfg_data[GH_W-1:0] == '0) ? GH_W'(1) : cfg_data[GH_W-1:0];
                end
                REG_RADIUS:
                begin
                    r_next = (cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS))
                           ? RAD_W'(MAX_RADIUS) : cfg_data[RAD_W-1:0];
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
            in_x_next = '0;
            in_y_next = '0;
            pre_next  = '0;
            hx_next   = '0;
            hy_next   = '0;
            done_next = 1'b0;
        end
        else if (in_fire && !done_reg)
        begin
            if (row_end_in)
            begin
                in_x_next = '0;
                in_y_next = in_y_reg + ROW_W'(1);
            end
            else
            begin
                in_x_next = in_x_reg + COL_W'(1);
            end
            if (!center_ok)
            begin
                pre_next = pre_reg + RAD_W'(1);
            end
            else
            begin
                if (row_end_h)
                begin
                    hx_next = '0;
                    hy_next = hy_reg + ROW_W'(1);
                end
                else
                begin
                    hx_next = hx_reg + COL_W'(1);
                end
                if (hy_reg == last_row && row_end_h)
                begin
                    done_next = 1'b1;
                end
                s1_valid_next = 1'b1;
                s1_next.x     = hx_reg;
                s1_next.top   = (hy_reg == '0);
                s1_next.emit  = (hy_reg >= ROW_W'(r_reg));
                s1_next.last  = (hy_reg == last_row) && row_end_h;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= GW_W'(1024);
            h_reg         <= GH_W'(1024);
            r_reg         <= RAD_W'(1);
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            pre_reg       <= '0;
            hx_reg        <= '0;
            hy_reg        <= '0;
            done_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            r_reg         <= r_next;
            in_x_reg      <= in_x_next;
            in_y_reg      <= in_y_next;
            pre_reg       <= pre_next;
            hx_reg        <= hx_next;
            hy_reg        <= hy_next;
            done_reg      <= done_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (s1_fire)
        begin
            wb_addr_reg <= s1_reg.x;
            wb_data_reg <= d_new;
        end
        if (s1_fire && s1_reg.emit)
        begin
            occupied_reg <= (d_new <= d_limit);
            last_reg     <= s1_reg.last;
        end
    end

    ogi_row_win u_row_win (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (restart),
        .shift_en (in_fire && !done_reg),
        .cell_bit (cell_bit),
        .center_x (s1_reg.x),
        .w_eff    (w_reg),
        .r_eff    (r_reg),
        .hit      (hit)
    );

    ogi_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (DIST_W),
        .AW    (COL_W)
    ) u_col_dist (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_reg.x),
        .wdata (d_new),
        .re    (s1_load),
        .raddr (hx_reg),
        .rdata (mem_rdata)
    );

    // rows since the last horizontal hit in this column, saturating
    always_comb
    begin
        d_limit = DIST_W'(r_reg) + DIST_W'(r_reg);
        d_prev  = (wb_addr_reg == s1_reg.x) ? wb_data_reg : mem_rdata;
        if (hit)
        begin
            d_new = '0;
        end
        else if (s1_reg.top || d_prev >= DIST_W'(DIST_SAT))
        begin
            d_new = DIST_W'(DIST_SAT);
        end
        else
        begin
            d_new = d_prev + DIST_W'(1);
        end
    end

    assign out_valid = out_valid_reg;
    assign occupied  = occupied_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_no_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !s1_load)
        else $error("work stage loaded after the final grid cell");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |-> !in_ready)
        else $error("input taken while the working stage is stalled");

    a_last_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> done_reg)
        else $error("final result shown before the stream was closed");

    a_center_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        GW_W'(hx_reg) < w_reg)
        else $error("center column beyond the grid width");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for occupancy_grid_inflation: predicted square dilation vs. RTL.
`default_nettype none

module tb;
    import ogi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OCC_DEPTH   = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int SETTLE      = 6;
    localparam int TAIL        = 20;
    localparam int RAND_ITEMS  = 250;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [CFG_W-1:0]  data;
        logic [CELL_W-1:0] cell_byte;
        logic              drn;
        logic              chk;
        logic              occ;
        logic              lst;
    } probe_row_t;

    typedef struct packed {
        logic occ;
        logic lst;
    } mark_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [CELL_W-1:0] cell_value = '0;
    logic              drain      = 1'b0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              occupied;
    logic              last;
    logic              cfg_we     = 1'b0;
    logic [IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_W-1:0]  cfg_data   = '0;

    logic [GW_W-1:0]  grid_w_reg = 11'd1024;
    logic [GH_W-1:0]  grid_h_reg = 16'd1024;
    logic [RAD_W-1:0] rad_reg    = 4'd1;
    bit               occ_hist [OCC_DEPTH];
    longint           cells_in   = 0;
    longint           marks_out  = 0;
    mark_t            inflated_q [$];
    mark_t            due;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_len   = 0;
    int fail_cnt   = 0;
    int rand_items = 0;
    int cycle_cnt  = 0;
    int pidx       = 0;
    int dens_pick [4] = '{3, 15, 40, 85};

    probe_row_t probe_tab [23];

    occupancy_grid_inflation uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .drain      (drain),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .occupied   (occupied),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_len--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (inflated_q.size() == 0)
            begin
                $error("unexpected result: occupied %0d last %0d", occupied, last);
                fail_cnt++;
            end
            else
            begin
                due = inflated_q.pop_front();
                if (occupied !== due.occ)
                begin
                    $error("occupied: expected %0d, got %0d", due.occ, occupied);
                    fail_cnt++;
                end
                if (last !== due.lst)
                begin
                    $error("last: expected %0d, got %0d", due.lst, last);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic longint eff_w();
        if (grid_w_reg == 0)
            return 1;
        return (grid_w_reg > MAX_WIDTH) ? MAX_WIDTH : grid_w_reg;
    endfunction

    function automatic longint eff_h();
        return (grid_h_reg == 0) ? 1 : grid_h_reg;
    endfunction

    function automatic longint eff_r();
        return (rad_reg > MAX_RADIUS) ? MAX_RADIUS : rad_reg;
    endfunction

    function automatic bit dilate_step(input logic [CELL_W-1:0] cv, input logic dr,
                                       output logic occ, output logic lst);
        longint w, h, r, total, lag, c, y, x, ylo, yhi, xlo, xhi;
        w = eff_w();
        h = eff_h();
        r = eff_r();
        total = w * h;
        lag = r * w + r;
        occ = 1'b0;
        lst = 1'b0;
        if (cells_in >= total + lag)
            return 0;
        occ_hist[cells_in % OCC_DEPTH] = !dr && (cells_in < total) && (cv != 0);
        cells_in++;
        if (cells_in <= lag)
            return 0;
        c = marks_out;
        y = c / w;
        x = c % w;
        ylo = (y >= r) ? y - r : 0;
        yhi = (y + r < h) ? y + r : h - 1;
        xlo = (x >= r) ? x - r : 0;
        xhi = (x + r < w) ? x + r : w - 1;
        for (longint yy = ylo; yy <= yhi; yy++)
            for (longint xx = xlo; xx <= xhi; xx++)
                if (occ_hist[(yy * w + xx) % OCC_DEPTH])
                    occ = 1'b1;
        marks_out = c + 1;
        lst = (c == total - 1);
        return 1;
    endfunction

    task automatic offer_cell(input logic [CELL_W-1:0] cv, input logic dr,
                              input logic chk, input logic t_occ, input logic t_lst);
        logic  occ, lst;
        mark_t m;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= cv;
        drain      <= dr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (dilate_step(cv, dr, occ, lst))
        begin
            if (chk)
                m = '{t_occ, t_lst};
            else
                m = '{occ, lst};
            inflated_q = {inflated_q, m};
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (inflated_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  grid_w_reg = val[GW_W-1:0];
            REG_GRID_HEIGHT: grid_h_reg = val[GH_W-1:0];
            REG_RADIUS:      rad_reg = val[RAD_W-1:0];
            default:         return;
        endcase
        foreach (occ_hist[i])
            occ_hist[i] = 1'b0;
        cells_in = 0;
        marks_out = 0;
    endtask

    task automatic run_grid(input int n_items, input int dens, input bit pause_mid);
        longint            total;
        logic [CELL_W-1:0] cv;
        logic              dr;
        total = eff_w() * eff_h();
        for (int k = 0; k < n_items; k++)
        begin
            cv = $urandom_range(255, 1);
            dr = 1'b0;
            if (k < total)
            begin
                if ($urandom_range(99) < 4)
                    dr = 1'b1;
                else if ($urandom_range(99) >= dens)
                    cv = '0;
            end
            else
            begin
                cv = $urandom_range(255);
                dr = $urandom_range(1);
            end
            if (pause_mid && k == n_items / 2 && k != 0)
                wait_drained();
            offer_cell(cv, dr, 1'b0, 1'b0, 1'b0);
            rand_items++;
        end
    endtask

    task automatic run_phase(input logic [GW_W-1:0] w, input logic [GH_W-1:0] h,
                             input logic [RAD_W-1:0] r, input int n_items, input int dens,
                             input int mode, input bit pause_mid, input int hold);
        int               n;
        int               s;
        logic [IDX_W-1:0] idx;
        s = $urandom_range(2);
        for (int j = 0; j < 3; j++)
        begin
            idx = IDX_W'((s + j) % 3);
            wait_drained();
            case (idx)
                REG_GRID_WIDTH:  write_reg(idx, {5'($urandom_range(31)), w});
                REG_GRID_HEIGHT: write_reg(idx, h);
                default:         write_reg(idx, {12'($urandom), r});
            endcase
        end
        if ($urandom_range(3) == 0)
        begin
            wait_drained();
            write_reg(REG_NONE, 16'($urandom));
        end
        case (mode % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 46; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 10; stall_pct = 10; end
        endcase
        hold_len = hold;
        if (n_items < 0)
            n = int'(eff_w() * eff_h() + eff_r() * eff_w() + eff_r()) + $urandom_range(3);
        else
            n = n_items;
        run_grid(n, dens, pause_mid);
    endtask

    initial
    begin
        probe_tab = '{
            '{ROW_CFG,  REG_GRID_WIDTH,  16'hF803, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  REG_GRID_HEIGHT, 16'h0002, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  REG_RADIUS,      16'h0001, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h55, 1'b1, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'hAA, 1'b0, 1'b1, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h01, 1'b0, 1'b1, 1'b1, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h80, 1'b1, 1'b1, 1'b1, 1'b1},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  REG_RADIUS,      16'hFFF0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h01, 1'b0, 1'b1, 1'b1, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h80, 1'b0, 1'b1, 1'b1, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
            '{ROW_CFG,  REG_NONE,        16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'hFE, 1'b1, 1'b1, 1'b0, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h7F, 1'b0, 1'b1, 1'b1, 1'b0},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1},
            '{ROW_ITEM, REG_NONE,        16'h0000, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // check reset register values with a partial stream at 1024 x 1024, radius 1
        run_grid(1040, 5, 1'b0);

        foreach (probe_tab[i])
        begin
            if (probe_tab[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(probe_tab[i].idx, probe_tab[i].data);
            end
            else
                offer_cell(probe_tab[i].cell_byte, probe_tab[i].drn, probe_tab[i].chk,
                           probe_tab[i].occ, probe_tab[i].lst);
        end

        run_phase(11'd2047, 16'd2,     4'd0,  60,   10, 1, 1'b0, 0);
        run_phase(11'd8,    16'd8,     4'd1,  -1,   30, 0, 1'b1, 300);
        run_phase(11'd0,    16'd20,    4'd2,  -1,   20, 2, 1'b0, 0);
        run_phase(11'd12,   16'd0,     4'd3,  -1,   20, 3, 1'b0, 0);
        run_phase(11'd5,    16'd4,     4'd0,  -1,   40, 1, 1'b0, 0);
        run_phase(11'd2,    16'd20,    4'd15, -1,   5,  2, 1'b0, 0);
        run_phase(11'd5,    16'hFFFF,  4'd2,  100,  15, 3, 1'b0, 0);
        run_phase(11'd1,    16'd1,     4'd0,  -1,   50, 0, 1'b0, 0);

        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            run_phase(($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(12, 1)),
                      ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(10, 1)),
                      ($urandom_range(6) == 0) ? 4'($urandom_range(15, 5))
                                               : 4'($urandom_range(4, 0)),
                      -1, dens_pick[$urandom_range(3)], pidx,
                      ($urandom_range(3) == 0), 0);
            pidx++;
        end

        wait_drained();
        repeat (TAIL) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ogi_pkg.sv
sv/ogi_ram.sv
sv/ogi_row_win.sv
sv/occupancy_grid_inflation.sv
tb/tb.sv
